// File: design/mbq_pkg.sv
package mbq_pkg;

    localparam int CH_W     = 4;
    localparam int SMP_W    = 24;
    localparam int GAIN_W   = 16;
    localparam int CFG_W    = 24;
    localparam int ADDR_W   = 3;
    localparam int NUM_CHANNELS_DEF = 16;

    typedef enum logic [2:0] {
        M_B0X,
        M_B1X1,
        M_B2X2,
        M_A1Y1,
        M_A2Y2,
        M_DRY,
        M_WET
    } t_msel;

    typedef enum logic [1:0] {
        A_NONE,
        A_LOAD,
        A_ADD,
        A_SUB
    } t_aop;

    typedef struct packed {
        logic  load_in;
        t_msel msel;
        t_aop  aop;
        logic  wet_ld;
        logic  hist_wr;
        logic  res_ld;
        logic  out_ld;
    } t_dp_cmd;

    typedef struct packed {
        logic chan_en;
    } t_dp_sts;

endpackage

// File: design/multichannel_biquad_lowpass_core.sv
// A filtered channel is processed by the single shared 24x24 multiplier
// stepping through seven products; a passthrough channel goes from idle
// straight to the output stage. o_stall is high until the word has been
// moved to the output register, so no new word is accepted before then.
// Reset is synchronous, active low: it clears the history of every channel and
// loads the register defaults (unity wet gain, filtering disabled).
module multichannel_biquad_lowpass_core #(
    parameter int NUM_CHANNELS = mbq_pkg::NUM_CHANNELS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [mbq_pkg::ADDR_W-1:0]          i_cfg_addr,
    input  logic [mbq_pkg::CFG_W-1:0]           i_cfg_data,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic [mbq_pkg::CH_W-1:0]            i_channel,
    input  logic signed [mbq_pkg::SMP_W-1:0]    i_sample_in,
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic signed [mbq_pkg::SMP_W-1:0]    o_sample_out,
    output logic [mbq_pkg::CH_W-1:0]            o_channel_out
);
    import mbq_pkg::*;

    t_dp_cmd cmd;
    t_dp_sts sts;

    mbq_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    mbq_dp #(
        .NUM_CHANNELS (NUM_CHANNELS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_data    (i_cfg_data),
        .i_channel     (i_channel),
        .i_sample_in   (i_sample_in),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .o_sample_out  (o_sample_out),
        .o_channel_out (o_channel_out)
    );

endmodule

// File: design/mbq_dp.sv
module mbq_dp #(
    parameter int NUM_CHANNELS = mbq_pkg::NUM_CHANNELS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [mbq_pkg::ADDR_W-1:0]          i_cfg_addr,
    input  logic [mbq_pkg::CFG_W-1:0]           i_cfg_data,
    input  logic [mbq_pkg::CH_W-1:0]            i_channel,
    input  logic signed [mbq_pkg::SMP_W-1:0]    i_sample_in,
    input  mbq_pkg::t_dp_cmd                    i_cmd,
    output mbq_pkg::t_dp_sts                    o_sts,
    output logic signed [mbq_pkg::SMP_W-1:0]    o_sample_out,
    output logic [mbq_pkg::CH_W-1:0]            o_channel_out
);
    import mbq_pkg::*;

    localparam int IDX_W  = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam int EXT_W  = CH_W + 2;
    localparam int PROD_W = 2 * SMP_W;
    localparam int ACC_W  = PROD_W + 3;

    localparam logic [ADDR_W-1:0] REG_COEF_B0  = ADDR_W'(0);
    localparam logic [ADDR_W-1:0] REG_COEF_B1  = ADDR_W'(1);
    localparam logic [ADDR_W-1:0] REG_COEF_B2  = ADDR_W'(2);
    localparam logic [ADDR_W-1:0] REG_COEF_A1  = ADDR_W'(3);
    localparam logic [ADDR_W-1:0] REG_COEF_A2  = ADDR_W'(4);
    localparam logic [ADDR_W-1:0] REG_WET_GAIN = ADDR_W'(5);
    localparam logic [ADDR_W-1:0] REG_DRY_GAIN = ADDR_W'(6);
    localparam logic [ADDR_W-1:0] REG_CH_EN    = ADDR_W'(7);

    localparam logic [GAIN_W-1:0] WET_GAIN_RST = GAIN_W'(32768);

    localparam logic signed [ACC_W-1:0] RND20   = ACC_W'(1 << 19);
    localparam logic signed [ACC_W-1:0] RND15   = ACC_W'(1 << 14);
    localparam logic signed [ACC_W-1:0] SAT_MAX = ACC_W'(8388607);
    localparam logic signed [ACC_W-1:0] SAT_MIN = -ACC_W'(8388608);

    function automatic logic signed [SMP_W-1:0] sat24(input logic signed [ACC_W-1:0] v);
        logic signed [SMP_W-1:0] r;
        if (v > SAT_MAX) begin
            r = SAT_MAX[SMP_W-1:0];
        end else if (v < SAT_MIN) begin
            r = SAT_MIN[SMP_W-1:0];
        end else begin
            r = v[SMP_W-1:0];
        end
        return r;
    endfunction

    logic signed [SMP_W-1:0]  r_b0, r_b1, r_b2, r_a1, r_a2;
    logic [GAIN_W-1:0]        r_wet_gain, r_dry_gain, r_ch_en;

    logic signed [SMP_W-1:0]  r_in_h1  [NUM_CHANNELS];
    logic signed [SMP_W-1:0]  r_in_h2  [NUM_CHANNELS];
    logic signed [SMP_W-1:0]  r_out_h1 [NUM_CHANNELS];
    logic signed [SMP_W-1:0]  r_out_h2 [NUM_CHANNELS];

    logic signed [SMP_W-1:0]  r_x, r_x1, r_x2, r_y1, r_y2, r_wet, r_res;
    logic [CH_W-1:0]          r_ch;
    logic [IDX_W-1:0]         r_idx;
    logic signed [PROD_W-1:0] r_prod;
    logic signed [ACC_W-1:0]  r_acc;
    logic signed [SMP_W-1:0]  r_out_sample;
    logic [CH_W-1:0]          r_out_ch;

    logic [EXT_W-1:0]         ch_ext;
    logic [IDX_W-1:0]         in_idx;
    logic                     chan_en;
    logic signed [SMP_W-1:0]  mul_a, mul_b;
    logic signed [ACC_W-1:0]  prod_ext;
    logic signed [ACC_W-1:0]  sum20, sum15, sh20, sh15;

    assign ch_ext  = EXT_W'(i_channel);
    assign in_idx  = ch_ext[IDX_W-1:0];
    assign chan_en = (int'(i_channel) < NUM_CHANNELS) && r_ch_en[i_channel];
    assign o_sts.chan_en = chan_en;

    always_comb begin
        case (i_cmd.msel)
            M_B0X: begin
                mul_a = r_x;
                mul_b = r_b0;
            end
            M_B1X1: begin
                mul_a = r_x1;
                mul_b = r_b1;
            end
            M_B2X2: begin
                mul_a = r_x2;
                mul_b = r_b2;
            end
            M_A1Y1: begin
                mul_a = r_y1;
                mul_b = r_a1;
            end
            M_A2Y2: begin
                mul_a = r_y2;
                mul_b = r_a2;
            end
            M_DRY: begin
                mul_a = r_x;
                mul_b = {{(SMP_W-GAIN_W){1'b0}}, r_dry_gain};
            end
            M_WET: begin
                mul_a = r_wet;
                mul_b = {{(SMP_W-GAIN_W){1'b0}}, r_wet_gain};
            end
            default: begin
                mul_a = r_x;
                mul_b = r_b0;
            end
        endcase
    end

    assign prod_ext = {{(ACC_W-PROD_W){r_prod[PROD_W-1]}}, r_prod};
    assign sum20    = r_acc + RND20;
    assign sum15    = r_acc + RND15;
    assign sh20     = sum20 >>> 20;
    assign sh15     = sum15 >>> 15;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b0       <= '0;
            r_b1       <= '0;
            r_b2       <= '0;
            r_a1       <= '0;
            r_a2       <= '0;
            r_wet_gain <= WET_GAIN_RST;
            r_dry_gain <= '0;
            r_ch_en    <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                REG_COEF_B0:  r_b0       <= i_cfg_data[SMP_W-1:0];
                REG_COEF_B1:  r_b1       <= i_cfg_data[SMP_W-1:0];
                REG_COEF_B2:  r_b2       <= i_cfg_data[SMP_W-1:0];
                REG_COEF_A1:  r_a1       <= i_cfg_data[SMP_W-1:0];
                REG_COEF_A2:  r_a2       <= i_cfg_data[SMP_W-1:0];
                REG_WET_GAIN: r_wet_gain <= i_cfg_data[GAIN_W-1:0];
                REG_DRY_GAIN: r_dry_gain <= i_cfg_data[GAIN_W-1:0];
                REG_CH_EN:    r_ch_en    <= i_cfg_data[GAIN_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_CHANNELS; i++) begin
                r_in_h1[i]  <= '0;
                r_in_h2[i]  <= '0;
                r_out_h1[i] <= '0;
                r_out_h2[i] <= '0;
            end
        end else if (i_cmd.hist_wr) begin
            r_in_h2[r_idx]  <= r_x1;
            r_in_h1[r_idx]  <= r_x;
            r_out_h2[r_idx] <= r_y1;
            r_out_h1[r_idx] <= r_wet;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_x   <= i_sample_in;
            r_res <= i_sample_in;
            r_ch  <= i_channel;
            if (chan_en) begin
                r_idx <= in_idx;
                r_x1  <= r_in_h1[in_idx];
                r_x2  <= r_in_h2[in_idx];
                r_y1  <= r_out_h1[in_idx];
                r_y2  <= r_out_h2[in_idx];
            end
        end
        r_prod <= mul_a * mul_b;
        case (i_cmd.aop)
            A_LOAD:  r_acc <= prod_ext;
            A_ADD:   r_acc <= r_acc + prod_ext;
            A_SUB:   r_acc <= r_acc - prod_ext;
            default: r_acc <= r_acc;
        endcase
        if (i_cmd.wet_ld) begin
            r_wet <= sat24(sh20);
        end
        if (i_cmd.res_ld) begin
            r_res <= sat24(sh15);
        end
        if (i_cmd.out_ld) begin
            r_out_sample <= r_res;
            r_out_ch     <= r_ch;
        end
    end

    assign o_sample_out  = r_out_sample;
    assign o_channel_out = r_out_ch;

endmodule

// File: design/mbq_ctrl.sv
module mbq_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_stall,
    output logic             o_valid,
    input  logic             i_stall,
    input  mbq_pkg::t_dp_sts i_sts,
    output mbq_pkg::t_dp_cmd o_cmd
);
    import mbq_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MAC,
        S_WET,
        S_MIXM,
        S_MIXA,
        S_FIN,
        S_DONE
    } t_state;

    localparam logic [2:0] MAC_LAST = 3'd5;

    t_state     r_state;
    logic [2:0] r_cnt;
    logic       r_out_valid;
    t_dp_cmd    cmd;

    always_comb begin
        cmd         = '0;
        cmd.msel    = M_B0X;
        cmd.aop     = A_NONE;
        unique case (r_state)
            S_IDLE: begin
                cmd.load_in = i_valid;
            end
            S_MAC: begin
                case (r_cnt)
                    3'd0: begin
                        cmd.msel = M_B0X;
                        cmd.aop  = A_NONE;
                    end
                    3'd1: begin
                        cmd.msel = M_B1X1;
                        cmd.aop  = A_LOAD;
                    end
                    3'd2: begin
                        cmd.msel = M_B2X2;
                        cmd.aop  = A_ADD;
                    end
                    3'd3: begin
                        cmd.msel = M_A1Y1;
                        cmd.aop  = A_ADD;
                    end
                    3'd4: begin
                        cmd.msel = M_A2Y2;
                        cmd.aop  = A_SUB;
                    end
                    default: begin
                        cmd.msel = M_DRY;
                        cmd.aop  = A_SUB;
                    end
                endcase
            end
            S_WET: begin
                cmd.wet_ld = 1'b1;
                cmd.aop    = A_LOAD;
            end
            S_MIXM: begin
                cmd.msel = M_WET;
            end
            S_MIXA: begin
                cmd.aop     = A_ADD;
                cmd.hist_wr = 1'b1;
            end
            S_FIN: begin
                cmd.res_ld = 1'b1;
            end
            S_DONE: begin
                cmd.out_ld = !r_out_valid || !i_stall;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_cnt   <= '0;
                        r_state <= i_sts.chan_en ? S_MAC : S_DONE;
                    end
                end
                S_MAC: begin
                    r_cnt <= r_cnt + 3'd1;
                    if (r_cnt == MAC_LAST) begin
                        r_state <= S_WET;
                    end
                end
                S_WET:  r_state <= S_MIXM;
                S_MIXM: r_state <= S_MIXA;
                S_MIXA: r_state <= S_FIN;
                S_FIN:  r_state <= S_DONE;
                S_DONE: begin
                    if (cmd.out_ld) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
            if (cmd.out_ld) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_cmd   = cmd;
    assign o_stall = (r_state != S_IDLE);
    assign o_valid = r_out_valid;

`ifndef SYNTHESIS
    a_pass_to_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall && !i_sts.chan_en) |=> (r_state == S_DONE))
        else $error("disabled channel did not go straight to output");

    a_filter_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall && i_sts.chan_en) |=> (r_state == S_MAC && r_cnt == 3'd0))
        else $error("enabled channel did not start the filter sequence");

    a_done_delivers: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && !(o_valid && i_stall)) |=> (o_valid && r_state == S_IDLE))
        else $error("finished word not moved to the output register");

    a_hist_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.hist_wr |=> (r_state == S_FIN && !o_cmd.hist_wr))
        else $error("history update out of sequence");
`endif

endmodule
